FILE: src/rlcm_pkg.sv
`timescale 1ns / 1ps
// Package for the radial log raised-cosine mask generator.
// Holds register indexes, band codes, fixed-point constants and the series divisors.
// Depends on nothing; used by radial_log_cosine_mask_gen.
package rlcm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_INNER_RADIUS = 2'd2;
    localparam logic [1:0] CFG_OUTER_RADIUS = 2'd3;

    // Register values after reset
    localparam logic [12:0] DEF_GRID_WIDTH   = 13'd256;
    localparam logic [12:0] DEF_GRID_HEIGHT  = 13'd256;
    localparam logic [15:0] DEF_INNER_RADIUS = 16'd1024;
    localparam logic [15:0] DEF_OUTER_RADIUS = 16'd2048;

    // Fraction bits of the output gains
    localparam int DEF_GAIN_FRAC_BITS = 15;

    // pi/2 and 1.0 in Q.30
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

    // Band of a grid position
    typedef enum logic [1:0] {
        ZONE_INNER = 2'd0,
        ZONE_TRANS = 2'd1,
        ZONE_OUTER = 2'd2
    } zone_t;

    // Divisor of series term n: lane 0 is the cosine, lane 1 the sine.
    function automatic int tay_div(input int lane, input int n);
        int a;
        begin
            a = 2 * n - 1 + lane;
            return a * (a + 1);
        end
    endfunction

endpackage

FILE: src/radial_log_cosine_mask_gen.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; every stage of the pipeline advances on each clock.
// The pipeline length is set by the bit-per-stage square root (25 stages), the divider (17),
// the logarithm squarings (16) and the series (18). busy is always low.
// Reset clears the valid chain and loads the default grid size and radii.
module radial_log_cosine_mask_gen #(
    parameter int GAIN_FRAC_BITS = rlcm_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] column,
    input  logic [11:0] row,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [15:0] lowpass_gain,
    output logic [15:0] highpass_gain,
    output logic [1:0]  band_zone
);
    import rlcm_pkg::*;

    localparam int LAT    = 84;
    localparam int ZN_LEN = 81;
    localparam int RND_SH = 30 - GAIN_FRAC_BITS;
    localparam logic [31:0] RND_ADD = 32'd1 << (29 - GAIN_FRAC_BITS);
    localparam logic [31:0] FULL_W  = 32'd1 << GAIN_FRAC_BITS;
    localparam logic [15:0] FULL_GAIN = FULL_W[15:0];

    // Configuration registers
    logic [12:0] grid_width_reg, grid_height_reg;
    logic [15:0] inner_radius_reg, outer_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg   <= DEF_GRID_WIDTH;
            grid_height_reg  <= DEF_GRID_HEIGHT;
            inner_radius_reg <= DEF_INNER_RADIUS;
            outer_radius_reg <= DEF_OUTER_RADIUS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data[12:0];
                CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[12:0];
                CFG_INNER_RADIUS: inner_radius_reg <= cfg_data;
                CFG_OUTER_RADIUS: outer_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Values derived from the configuration; they settle while the block is idle.
    logic [31:0] in2_reg, out2_reg;
    logic [23:0] lo_reg, d_reg;

    always_ff @(posedge clk)
    begin
        in2_reg  <= 32'(inner_radius_reg) * 32'(inner_radius_reg);
        out2_reg <= 32'(outer_radius_reg) * 32'(outer_radius_reg);
        lo_reg   <= {inner_radius_reg, 8'd0};
        d_reg    <= (outer_radius_reg > inner_radius_reg)
                    ? {outer_radius_reg - inner_radius_reg, 8'd0} : 24'd0;
    end

    assign busy = 1'b0;

    // Valid chain, one bit per stage
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    assign done = vld_reg[LAT-1];

    // Stage 1: wrap the position to signed frequencies.
    logic signed [13:0] k_next, l_next, k_reg, l_reg;

    always_comb
    begin
        if ({1'b0, column} <= {1'b0, grid_width_reg[12:1]})
            k_next = {2'b00, column};
        else
            k_next = {2'b00, column} - {1'b0, grid_width_reg};
        if ({1'b0, row} <= {1'b0, grid_height_reg[12:1]})
            l_next = {2'b00, row};
        else
            l_next = {2'b00, row} - {1'b0, grid_height_reg};
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        l_reg <= l_next;
    end

    // Stage 2: squares of both frequencies.
    logic signed [27:0] kk_full, ll_full;
    logic [23:0] kk_reg, ll_reg;

    assign kk_full = k_reg * k_reg;
    assign ll_full = l_reg * l_reg;

    always_ff @(posedge clk)
    begin
        kk_reg <= kk_full[23:0];
        ll_reg <= ll_full[23:0];
    end

    // Stage 3: squared radius in Q.8 and the band decision.
    logic [24:0] sum_sq;
    logic [32:0] s_next;
    zone_t zone_next;
    zone_t zn_reg [0:ZN_LEN-1];

    assign sum_sq = {1'b0, kk_reg} + {1'b0, ll_reg};
    assign s_next = {sum_sq, 8'd0};

    always_comb
    begin
        if (s_next > {1'b0, out2_reg})
            zone_next = ZONE_OUTER;
        else if (s_next < {1'b0, in2_reg})
            zone_next = ZONE_INNER;
        else
            zone_next = ZONE_TRANS;
    end

    always_ff @(posedge clk)
    begin
        zn_reg[0] <= zone_next;
    end

    // The band travels alongside the arithmetic.
    for (genvar i = 1; i < ZN_LEN; i++)
    begin : g_zone
        always_ff @(posedge clk)
        begin
            zn_reg[i] <= zn_reg[i-1];
        end
    end

    // Square root of s * 2^16, one result bit per stage.
    logic [49:0] sq_rem_reg  [0:25];
    logic [24:0] sq_root_reg [0:25];

    always_ff @(posedge clk)
    begin
        sq_rem_reg[0]  <= {1'b0, s_next, 16'd0};
        sq_root_reg[0] <= '0;
    end

    for (genvar j = 1; j <= 25; j++)
    begin : g_sqrt
        localparam int B = 25 - j;
        logic [49:0] trial;
        logic        fit;

        assign trial = ({25'd0, sq_root_reg[j-1]} << (B + 1)) | (50'd1 << (2 * B));
        assign fit   = sq_rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j]  <= fit ? sq_rem_reg[j-1] - trial : sq_rem_reg[j-1];
            sq_root_reg[j] <= fit ? (sq_root_reg[j-1] | (25'd1 << B)) : sq_root_reg[j-1];
        end
    end

    // Distance into the transition band, then its ratio to the band width.
    logic [24:0] num_next;
    logic [41:0] dv_rem_reg [0:17];
    logic [16:0] dv_q_reg   [0:17];

    assign num_next = (sq_root_reg[25] > {1'b0, lo_reg})
                      ? sq_root_reg[25] - {1'b0, lo_reg} : 25'd0;

    always_ff @(posedge clk)
    begin
        dv_rem_reg[0] <= {1'b0, num_next, 16'd0};
        dv_q_reg[0]   <= '0;
    end

    for (genvar j = 1; j <= 17; j++)
    begin : g_div
        localparam int B = 17 - j;
        logic [41:0] dsh;
        logic        fit;

        assign dsh = {18'd0, d_reg} << B;
        assign fit = dv_rem_reg[j-1] >= dsh;

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j] <= fit ? dv_rem_reg[j-1] - dsh : dv_rem_reg[j-1];
            dv_q_reg[j]   <= fit ? (dv_q_reg[j-1] | (17'd1 << B)) : dv_q_reg[j-1];
        end
    end

    // Clamp the ratio and form 1 + t in Q.30 for the logarithm.
    logic [16:0] t_next;
    logic [30:0] lg_x_reg   [0:16];
    logic [15:0] lg_y_reg   [0:16];
    logic        lg_big_reg [0:16];

    always_comb
    begin
        if (d_reg == 24'd0)
            t_next = '0;
        else if (dv_q_reg[17] > 17'h10000)
            t_next = 17'h10000;
        else
            t_next = dv_q_reg[17];
    end

    always_ff @(posedge clk)
    begin
        lg_x_reg[0]   <= {1'b1, t_next[15:0], 14'd0};
        lg_y_reg[0]   <= '0;
        lg_big_reg[0] <= t_next[16];
    end

    // Logarithm: square and compare, one fraction bit per stage.
    for (genvar j = 1; j <= 16; j++)
    begin : g_log
        logic [61:0] prod;
        logic [31:0] x1;

        assign prod = {31'd0, lg_x_reg[j-1]} * {31'd0, lg_x_reg[j-1]};
        assign x1   = prod[61:30];

        always_ff @(posedge clk)
        begin
            lg_x_reg[j]   <= x1[31] ? x1[31:1] : x1[30:0];
            lg_y_reg[j]   <= x1[31] ? (lg_y_reg[j-1] | (16'd1 << (16 - j))) : lg_y_reg[j-1];
            lg_big_reg[j] <= lg_big_reg[j-1];
        end
    end

    // Angle in Q.30, then its square.
    logic [16:0] u_val;
    logic [47:0] th_prod;
    logic [30:0] theta_reg;
    logic [61:0] x2_prod;

    assign u_val   = lg_big_reg[16] ? 17'h10000 : {1'b0, lg_y_reg[16]};
    assign th_prod = {31'd0, u_val} * {17'd0, HALFPI_Q30};
    assign x2_prod = {31'd0, theta_reg} * {31'd0, theta_reg};

    always_ff @(posedge clk)
    begin
        theta_reg <= th_prod[46:16];
    end

    // Series registers: lane 0 is the cosine, lane 1 the sine.
    logic [31:0]        x2a_reg [1:6];
    logic [31:0]        x2b_reg [1:6];
    logic [31:0]        x2c_reg [0:6];
    logic [31:0]        tc_term_reg [0:1][0:6];
    logic signed [33:0] tc_sum_reg  [0:1][0:6];
    logic [31:0]        pa_reg [0:1][1:6];
    logic signed [33:0] sa_reg [0:1][1:6];
    logic [31:0]        pb_reg [0:1][1:6];
    logic [31:0]        qb_reg [0:1][1:6];
    logic signed [33:0] sb_reg [0:1][1:6];

    always_ff @(posedge clk)
    begin
        x2c_reg[0]        <= x2_prod[61:30];
        tc_term_reg[0][0] <= ONE_Q30;
        tc_sum_reg[0][0]  <= signed'({2'b00, ONE_Q30});
        tc_term_reg[1][0] <= {1'b0, theta_reg};
        tc_sum_reg[1][0]  <= signed'({3'b000, theta_reg});
    end

    for (genvar n = 1; n <= 6; n++)
    begin : g_term
        // The angle square follows each term through its three stages.
        always_ff @(posedge clk)
        begin
            x2a_reg[n] <= x2c_reg[n-1];
            x2b_reg[n] <= x2a_reg[n];
            x2c_reg[n] <= x2b_reg[n];
        end

        for (genvar ln = 0; ln < 2; ln++)
        begin : g_lane
            localparam int DIV = tay_div(ln, n);
            localparam logic [63:0] RCP_W = (64'd1 << 32) / DIV;
            localparam logic [31:0] RCP = RCP_W[31:0];
            logic [63:0] prod_a, prod_b;
            logic [33:0] back, rest;
            logic [31:0] q_fix;

            // Multiply by the angle square, then divide by the term's constant
            // through its reciprocal, correcting a quotient that is one short.
            assign prod_a = {32'd0, tc_term_reg[ln][n-1]} * {32'd0, x2c_reg[n-1]};
            assign prod_b = {32'd0, pa_reg[ln][n]} * {32'd0, RCP};
            assign back   = {2'b00, qb_reg[ln][n]} * 34'(DIV);
            assign rest   = {2'b00, pb_reg[ln][n]} - back;
            assign q_fix  = (rest >= 34'(DIV)) ? qb_reg[ln][n] + 32'd1 : qb_reg[ln][n];

            always_ff @(posedge clk)
            begin
                pa_reg[ln][n]      <= prod_a[61:30];
                sa_reg[ln][n]      <= tc_sum_reg[ln][n-1];
                pb_reg[ln][n]      <= pa_reg[ln][n];
                qb_reg[ln][n]      <= prod_b[63:32];
                sb_reg[ln][n]      <= sa_reg[ln][n];
                tc_term_reg[ln][n] <= q_fix;
                if (n % 2 == 1)
                    tc_sum_reg[ln][n] <= sb_reg[ln][n] - signed'({2'b00, q_fix});
                else
                    tc_sum_reg[ln][n] <= sb_reg[ln][n] + signed'({2'b00, q_fix});
            end
        end
    end

    // Output stage: clamp to [0, 1], round half up, select by band.
    logic [31:0] clip_v [0:1];
    logic [31:0] rnd_v  [0:1];
    logic [15:0] lowpass_gain_reg, highpass_gain_reg;
    logic [1:0]  band_zone_reg;

    for (genvar ln = 0; ln < 2; ln++)
    begin : g_gain
        always_comb
        begin
            if (tc_sum_reg[ln][6] < 0)
                clip_v[ln] = '0;
            else if (tc_sum_reg[ln][6] > signed'({2'b00, ONE_Q30}))
                clip_v[ln] = ONE_Q30;
            else
                clip_v[ln] = tc_sum_reg[ln][6][31:0];
            rnd_v[ln] = (clip_v[ln] + RND_ADD) >> RND_SH;
        end
    end

    always_ff @(posedge clk)
    begin
        band_zone_reg <= zn_reg[ZN_LEN-1];
        case (zn_reg[ZN_LEN-1])
            ZONE_INNER:
            begin
                lowpass_gain_reg  <= FULL_GAIN;
                highpass_gain_reg <= '0;
            end
            ZONE_OUTER:
            begin
                lowpass_gain_reg  <= '0;
                highpass_gain_reg <= FULL_GAIN;
            end
            default:
            begin
                lowpass_gain_reg  <= rnd_v[0][15:0];
                highpass_gain_reg <= rnd_v[1][15:0];
            end
        endcase
    end

    assign lowpass_gain  = lowpass_gain_reg;
    assign highpass_gain = highpass_gain_reg;
    assign band_zone     = band_zone_reg;

    // Checks on timing and on the fixed gains of the outer bands.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result word without a start at the pipeline latency");

    a_inner_gain: assert property (@(posedge clk) disable iff (!rst_n)
        done && band_zone == ZONE_INNER |-> lowpass_gain == FULL_GAIN && highpass_gain == '0)
        else $error("inner band word with wrong gains");

    a_outer_gain: assert property (@(posedge clk) disable iff (!rst_n)
        done && band_zone == ZONE_OUTER |-> lowpass_gain == '0 && highpass_gain == FULL_GAIN)
        else $error("outer band word with wrong gains");

endmodule
